// ----- rtl/core/tcst_pkg.sv -----
// Shared types, codes and constants of the TCP client segment tracker.
package tcst_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [31:0] InitLocalSeq   = 32'd1000;
  localparam logic [15:0] MinHeaderBytes = 16'd20;

  typedef enum logic [1:0] {
    CONN_NONE        = 2'd0,
    CONN_SYN_SENT    = 2'd1,
    CONN_ESTABLISHED = 2'd2
  } conn_e;

  typedef enum logic [3:0] {
    STATUS_SYN_SENT        = 4'd0,
    STATUS_HANDSHAKE_DONE  = 4'd1,
    STATUS_DATA_ACKED      = 4'd2,
    STATUS_ACCEPTED_NO_ACK = 4'd3,
    STATUS_SHORT           = 4'd4,
    STATUS_RST             = 4'd5,
    STATUS_NOT_SYNACK      = 4'd6,
    STATUS_FIN_IN_SYNSENT  = 4'd7,
    STATUS_SYNACK_PAYLOAD  = 4'd8,
    STATUS_BAD_ACK         = 4'd9,
    STATUS_SYN_ESTABLISHED = 4'd10,
    STATUS_OUT_OF_ORDER    = 4'd11,
    STATUS_IDLE_STATE      = 4'd12
  } status_e;

  typedef enum logic [1:0] {
    KIND_CONNECT = 2'd0,
    KIND_SHORT   = 2'd1,
    KIND_RST     = 2'd2,
    KIND_SEGMENT = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] seq;
    logic [31:0] ackn;
    logic        fin;
    logic        syn;
    logic        ack;
    logic [15:0] payload;
    logic [16:0] virt;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic        send_segment;
    logic        send_syn;
    logic        send_ack;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] deliver_length;
    conn_e       state_after;
  } result_t;

endpackage

// ----- rtl/core/tcst_front.sv -----
// Front end: classifies each incoming word without reference to connection state.
module tcst_front (
  input  logic                 mode_i,
  input  logic [31:0]          seq_number_i,
  input  logic [31:0]          ack_number_i,
  input  logic                 fin_bit_i,
  input  logic                 syn_bit_i,
  input  logic                 rst_bit_i,
  input  logic                 ack_bit_i,
  input  logic [3:0]           data_offset_i,
  input  logic [15:0]          segment_length_i,
  output tcst_pkg::entry_t     entry_o
);

  logic [15:0] hdr_bytes;
  logic        too_short;

  assign hdr_bytes = {10'd0, data_offset_i, 2'b00};
  assign too_short = (segment_length_i < tcst_pkg::MinHeaderBytes) ||
                     (hdr_bytes > segment_length_i);

  always_comb begin
    priority if (!mode_i) begin
      entry_o.kind = tcst_pkg::KIND_CONNECT;
    end else if (too_short) begin
      entry_o.kind = tcst_pkg::KIND_SHORT;
    end else if (rst_bit_i) begin
      entry_o.kind = tcst_pkg::KIND_RST;
    end else begin
      entry_o.kind = tcst_pkg::KIND_SEGMENT;
    end
    entry_o.seq     = seq_number_i;
    entry_o.ackn    = ack_number_i;
    entry_o.fin     = fin_bit_i;
    entry_o.syn     = syn_bit_i;
    entry_o.ack     = ack_bit_i;
    // Only meaningful once the length check has passed.
    entry_o.payload = segment_length_i - hdr_bytes;
    entry_o.virt    = {1'b0, entry_o.payload} + {16'd0, fin_bit_i};
  end

endmodule

// ----- rtl/core/tcst_fifo.sv -----
// Short queue of classified words between the front and back ends.
module tcst_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tcst_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output tcst_pkg::entry_t head_o,
  output logic             empty_o
);

  tcst_pkg::entry_t                  mem_q [tcst_pkg::QDepth];
  logic [tcst_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [tcst_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [tcst_pkg::QCntW-1:0]        cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o  = (cnt_q == tcst_pkg::QCntW'(tcst_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tcst_pkg::QPtrW'(tcst_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tcst_pkg::QPtrW'(tcst_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/core/tcst_back.sv -----
// Back end: applies each classified word to the connection state and registers the result.
module tcst_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcst_pkg::entry_t  head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output tcst_pkg::result_t res_o
);

  tcst_pkg::conn_e   conn_q, conn_d;
  logic [31:0]       acked_q, acked_d;
  logic [31:0]       expected_q, expected_d;
  logic              res_valid_q;
  tcst_pkg::result_t res_q, res_d;
  logic [31:0]       acked_plus_one;
  logic [31:0]       new_acked;
  logic [31:0]       new_expected;

  assign pop_o          = !empty_i && (!res_valid_q || !res_stall_i);
  assign res_valid_o    = res_valid_q;
  assign res_o          = res_q;
  assign acked_plus_one = acked_q + 32'd1;
  assign new_acked      = head_i.ack ? head_i.ackn : acked_q;
  assign new_expected   = head_i.seq + {15'd0, head_i.virt};

  always_comb begin
    conn_d     = conn_q;
    acked_d    = acked_q;
    expected_d = expected_q;
    res_d      = '0;
    res_d.status = tcst_pkg::STATUS_IDLE_STATE;
    unique case (head_i.kind)
      tcst_pkg::KIND_CONNECT: begin
        conn_d             = tcst_pkg::CONN_SYN_SENT;
        res_d.status       = tcst_pkg::STATUS_SYN_SENT;
        res_d.send_segment = 1'b1;
        res_d.send_syn     = 1'b1;
        res_d.out_seq      = acked_q;
      end
      tcst_pkg::KIND_SHORT: res_d.status = tcst_pkg::STATUS_SHORT;
      tcst_pkg::KIND_RST:   res_d.status = tcst_pkg::STATUS_RST;
      tcst_pkg::KIND_SEGMENT: begin
        unique case (conn_q)
          tcst_pkg::CONN_SYN_SENT: begin
            priority if (!head_i.syn || !head_i.ack) begin
              res_d.status = tcst_pkg::STATUS_NOT_SYNACK;
            end else if (head_i.fin) begin
              res_d.status = tcst_pkg::STATUS_FIN_IN_SYNSENT;
            end else if (head_i.payload != '0) begin
              res_d.status = tcst_pkg::STATUS_SYNACK_PAYLOAD;
            end else if (head_i.ackn != acked_plus_one) begin
              res_d.status = tcst_pkg::STATUS_BAD_ACK;
            end else begin
              acked_d            = head_i.ackn;
              expected_d         = head_i.seq + 32'd1;
              conn_d             = tcst_pkg::CONN_ESTABLISHED;
              res_d.status       = tcst_pkg::STATUS_HANDSHAKE_DONE;
              res_d.send_segment = 1'b1;
              res_d.send_ack     = 1'b1;
              res_d.out_seq      = head_i.ackn;
              res_d.out_ack      = head_i.seq + 32'd1;
            end
          end
          tcst_pkg::CONN_ESTABLISHED: begin
            priority if (head_i.syn) begin
              res_d.status = tcst_pkg::STATUS_SYN_ESTABLISHED;
            end else if (head_i.seq != expected_q) begin
              res_d.status = tcst_pkg::STATUS_OUT_OF_ORDER;
            end else begin
              acked_d              = new_acked;
              expected_d           = new_expected;
              res_d.deliver_length = head_i.payload;
              if (head_i.virt != '0) begin
                res_d.status       = tcst_pkg::STATUS_DATA_ACKED;
                res_d.send_segment = 1'b1;
                res_d.send_ack     = 1'b1;
                res_d.out_seq      = new_acked;
                res_d.out_ack      = new_expected;
              end else begin
                res_d.status = tcst_pkg::STATUS_ACCEPTED_NO_ACK;
              end
            end
          end
          default: res_d.status = tcst_pkg::STATUS_IDLE_STATE;
        endcase
      end
      default: res_d.status = tcst_pkg::STATUS_IDLE_STATE;
    endcase
    res_d.state_after = conn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q      <= tcst_pkg::CONN_NONE;
      acked_q     <= tcst_pkg::InitLocalSeq;
      expected_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        conn_q     <= conn_d;
        acked_q    <= acked_d;
        expected_q <= expected_d;
      end
      if (pop_o) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// ----- rtl/core/tcp_client_segment_tracker_core.sv -----
// Top level of the TCP client segment tracker: front end, word queue and back end.
// A word accepted into the queue goes on to the back end, whose output register holds its result
// until the receiver takes it.
// Throughput: one word per cycle while the output is not stalled, as the back end updates the state for each word.
// Reset (rst_ni low, asynchronous) empties the queue and the output register and puts the
// connection at none, acknowledged local sequence 1000, expected remote sequence 0.
module tcp_client_segment_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] seq_number_i,
  input  logic [31:0] ack_number_i,
  input  logic        fin_bit_i,
  input  logic        syn_bit_i,
  input  logic        rst_bit_i,
  input  logic        ack_bit_i,
  input  logic [3:0]  data_offset_i,
  input  logic [15:0] segment_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic        send_segment_o,
  output logic        send_syn_o,
  output logic        send_ack_o,
  output logic [31:0] out_seq_o,
  output logic [31:0] out_ack_o,
  output logic [15:0] deliver_length_o,
  output logic [1:0]  state_after_o
);

  // The front end looks only at the word itself: it decides whether the word is a connect
  // request, a segment that is too short, a reset, or a segment that needs the connection
  // state, and it works out the payload length ahead of time.
  tcst_pkg::entry_t  front_entry;
  tcst_pkg::entry_t  q_head;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  tcst_pkg::result_t result;

  tcst_front u_front (
    .mode_i           (mode_i),
    .seq_number_i     (seq_number_i),
    .ack_number_i     (ack_number_i),
    .fin_bit_i        (fin_bit_i),
    .syn_bit_i        (syn_bit_i),
    .rst_bit_i        (rst_bit_i),
    .ack_bit_i        (ack_bit_i),
    .data_offset_i    (data_offset_i),
    .segment_length_i (segment_length_i),
    .entry_o          (front_entry)
  );

  // The queue decouples the two halves: input stalls only when it is full, so a result that
  // waits on the output does not immediately stop new words from coming in.
  assign in_stall_o = q_full;

  tcst_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // The back end owns the connection state and the output register. It takes the head word
  // whenever the output register is empty or is being emptied in the same cycle.
  tcst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (result)
  );

  assign status_o         = result.status;
  assign send_segment_o   = result.send_segment;
  assign send_syn_o       = result.send_syn;
  assign send_ack_o       = result.send_ack;
  assign out_seq_o        = result.out_seq;
  assign out_ack_o        = result.out_ack;
  assign deliver_length_o = result.deliver_length;
  assign state_after_o    = result.state_after;

endmodule

// ----- rtl/core/tcst_checker.sv -----
// Port-level assertions for the TCP client segment tracker, bound to its top level.
module tcst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  status_o,
  input logic        send_segment_o,
  input logic        send_syn_o,
  input logic        send_ack_o,
  input logic [31:0] out_seq_o,
  input logic [31:0] out_ack_o,
  input logic [15:0] deliver_length_o,
  input logic [1:0]  state_after_o
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(out_seq_o) && $stable(out_ack_o) && $stable(deliver_length_o))
    else $error("result changed while stalled");

  // A connect request always sends a bare SYN and leaves the connection in SYN sent.
  a_connect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tcst_pkg::STATUS_SYN_SENT) |->
    send_segment_o && send_syn_o && !send_ack_o && (out_ack_o == 32'd0) &&
    (state_after_o == tcst_pkg::CONN_SYN_SENT))
    else $error("connect result malformed");

  // Without a segment to send, its fields read as zero.
  a_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_segment_o |->
    !send_syn_o && !send_ack_o && (out_seq_o == 32'd0) && (out_ack_o == 32'd0))
    else $error("unused send fields not cleared");

  // Payload is only handed over on an accepted in-order segment of an open connection.
  a_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (deliver_length_o != 16'd0) |->
    ((status_o == tcst_pkg::STATUS_DATA_ACKED) ||
     (status_o == tcst_pkg::STATUS_ACCEPTED_NO_ACK)) &&
    (state_after_o == tcst_pkg::CONN_ESTABLISHED))
    else $error("payload delivered on a rejected segment");

endmodule

bind tcp_client_segment_tracker_core tcst_checker u_tcst_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench of the TCP client segment tracker core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcst_pkg::*;

  // Meaning of the mode bit of an input word.
  localparam logic MODE_CONNECT = 1'b0;
  localparam logic MODE_SEGMENT = 1'b1;

  localparam int unsigned RandomWords = 1550;
  localparam int unsigned MaxReports  = 10;
  localparam result_t     NoReply     = '0;

  // One input word as the sender sees it.
  typedef struct packed {
    logic        mode;
    logic [31:0] seq;
    logic [31:0] ackn;
    logic        fin;
    logic        syn;
    logic        rst;
    logic        ack;
    logic [3:0]  doff;
    logic [15:0] len;
  } seg_word_t;

  // A row of the directed script: the word, and where the outcome is obvious, the reply
  // written out by hand instead of the one worked out by the tracker model below.
  typedef struct {
    seg_word_t word;
    bit        typed;
    result_t   reply;
  } script_row_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic        mode_i           = 1'b0;
  logic [31:0] seq_number_i     = '0;
  logic [31:0] ack_number_i     = '0;
  logic        fin_bit_i        = 1'b0;
  logic        syn_bit_i        = 1'b0;
  logic        rst_bit_i        = 1'b0;
  logic        ack_bit_i        = 1'b0;
  logic [3:0]  data_offset_i    = '0;
  logic [15:0] segment_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [3:0]  status_o;
  logic        send_segment_o;
  logic        send_syn_o;
  logic        send_ack_o;
  logic [31:0] out_seq_o;
  logic [31:0] out_ack_o;
  logic [15:0] deliver_length_o;
  logic [1:0]  state_after_o;

  // Connection as the testbench believes it to be, updated when a word is accepted.
  conn_e       link_state      = CONN_NONE;
  logic [31:0] peer_acked_seq  = InitLocalSeq;
  logic [31:0] next_remote_seq = '0;

  // Replies still owed by the block, oldest first.
  result_t     pending_replies[$];
  script_row_t script[$];

  int unsigned fault_count     = 0;
  int unsigned words_sent      = 0;
  int unsigned replies_checked = 0;
  int unsigned status_tally[16];
  // When set, neither side inserts idle cycles, so the block runs back to back.
  bit          no_idle         = 1'b0;

  tcp_client_segment_tracker_core uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run of roughly 1600 words.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Tracker model. Works out the reply to one word and moves the connection on, exactly
  // as the block must: the rejection checks are applied in a fixed order, and all sequence
  // arithmetic wraps at 32 bits.
  function automatic result_t track_word(seg_word_t w);
    result_t     r;
    logic [17:0] hdr_bytes;
    logic [15:0] payload;
    logic [16:0] virt_len;
    r         = '0;
    hdr_bytes = {12'd0, w.doff, 2'b00};
    payload   = w.len - hdr_bytes[15:0];
    if (w.mode == MODE_CONNECT) begin
      // A connect is honoured in every state and restarts the handshake.
      link_state     = CONN_SYN_SENT;
      r.send_segment = 1'b1;
      r.send_syn     = 1'b1;
      r.out_seq      = peer_acked_seq;
      r.status       = STATUS_SYN_SENT;
    end else if (w.len < MinHeaderBytes || hdr_bytes > {2'b00, w.len}) begin
      // Too short, including a header that claims more bytes than the segment holds.
      r.status = STATUS_SHORT;
    end else if (w.rst) begin
      r.status = STATUS_RST;
    end else if (link_state == CONN_SYN_SENT) begin
      if (!w.syn || !w.ack) begin
        r.status = STATUS_NOT_SYNACK;
      end else if (w.fin) begin
        r.status = STATUS_FIN_IN_SYNSENT;
      end else if (payload != '0) begin
        r.status = STATUS_SYNACK_PAYLOAD;
      end else if (w.ackn != peer_acked_seq + 32'd1) begin
        r.status = STATUS_BAD_ACK;
      end else begin
        peer_acked_seq  = w.ackn;
        next_remote_seq = w.seq + 32'd1;
        link_state      = CONN_ESTABLISHED;
        r.send_segment  = 1'b1;
        r.send_ack      = 1'b1;
        r.out_seq       = peer_acked_seq;
        r.out_ack       = next_remote_seq;
        r.status        = STATUS_HANDSHAKE_DONE;
      end
    end else if (link_state == CONN_ESTABLISHED) begin
      if (w.syn) begin
        r.status = STATUS_SYN_ESTABLISHED;
      end else if (w.seq != next_remote_seq) begin
        r.status = STATUS_OUT_OF_ORDER;
      end else begin
        // FIN takes one sequence number of its own, on top of the payload.
        virt_len = {1'b0, payload} + {16'd0, w.fin};
        if (w.ack) begin
          peer_acked_seq = w.ackn;
        end
        next_remote_seq = w.seq + {15'd0, virt_len};
        if (virt_len != '0) begin
          r.send_segment = 1'b1;
          r.send_ack     = 1'b1;
          r.out_seq      = peer_acked_seq;
          r.out_ack      = next_remote_seq;
          r.status       = STATUS_DATA_ACKED;
        end else begin
          r.status = STATUS_ACCEPTED_NO_ACK;
        end
        r.deliver_length = payload;
      end
    end else begin
      r.status = STATUS_IDLE_STATE;
    end
    r.state_after = link_state;
    return r;
  endfunction

  function automatic seg_word_t seg(logic mode, logic [31:0] seq, logic [31:0] ackn,
                                    logic fin, logic syn, logic rst, logic ack,
                                    logic [3:0] doff, logic [15:0] len);
    seg_word_t w;
    w = '{mode, seq, ackn, fin, syn, rst, ack, doff, len};
    return w;
  endfunction

  function automatic result_t reply(status_e status, logic snd, logic s_syn, logic s_ack,
                                    logic [31:0] o_seq, logic [31:0] o_ack,
                                    logic [15:0] dlen, conn_e state);
    result_t r;
    r = '{status, snd, s_syn, s_ack, o_seq, o_ack, dlen, state};
    return r;
  endfunction

  // Random word shaped by the current connection state. Most words are the ones a
  // well-behaved peer would send next, so the run spends its time in the established
  // state; the rest are deliberately broken or plain noise.
  function automatic seg_word_t draw_word();
    seg_word_t   w;
    int unsigned pick;
    int unsigned body;
    w.mode = MODE_SEGMENT;
    w.seq  = $urandom();
    w.ackn = $urandom();
    w.fin  = 1'($urandom_range(0, 1));
    w.syn  = 1'($urandom_range(0, 1));
    w.rst  = 1'($urandom_range(0, 1));
    w.ack  = 1'($urandom_range(0, 1));
    w.doff = 4'($urandom_range(0, 15));
    w.len  = 16'($urandom_range(0, 65535));
    pick   = $urandom_range(0, 99);
    if (pick < 4 || (link_state == CONN_NONE && pick < 60)) begin
      // The remaining fields stay random: a connect must ignore them.
      w.mode = MODE_CONNECT;
    end else if (pick >= 90) begin
      // Pure noise, whatever the state.
    end else if (link_state == CONN_SYN_SENT) begin
      w.syn  = 1'b1;
      w.ack  = 1'b1;
      w.fin  = 1'b0;
      w.rst  = 1'b0;
      w.doff = 4'($urandom_range(5, 15));
      w.len  = {10'd0, w.doff, 2'b00};
      w.ackn = peer_acked_seq + 32'd1;
      case ($urandom_range(0, 11))
        0: w.syn = 1'b0;
        1: w.ack = 1'b0;
        2: w.fin = 1'b1;
        3: w.len = w.len + 16'($urandom_range(1, 1460));
        4: w.ackn = w.ackn ^ (32'd1 << $urandom_range(0, 31));
        5: w.rst = 1'b1;
        6: w.len = 16'($urandom_range(0, 19));
        default: ;
      endcase
    end else if (link_state == CONN_ESTABLISHED) begin
      w.syn  = 1'b0;
      w.rst  = 1'b0;
      w.seq  = next_remote_seq;
      w.fin  = ($urandom_range(0, 9) == 0);
      // Now and then a header shorter than the minimum, which is tolerated.
      w.doff = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 4)) :
                                             4'($urandom_range(5, 15));
      if ($urandom_range(0, 3) == 0) begin
        body = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        body = $urandom_range(0, 65535 - 4 * w.doff);
      end else begin
        body = $urandom_range(1, 1460);
      end
      w.len = 16'(4 * w.doff + body);
      if (w.len < MinHeaderBytes) begin
        w.len = MinHeaderBytes;
      end
      if ($urandom_range(0, 7) != 0) begin
        w.ackn = peer_acked_seq + 32'($urandom_range(0, 3000));
      end
      case ($urandom_range(0, 11))
        0: w.syn = 1'b1;
        1: w.seq = w.seq ^ (32'd1 << $urandom_range(0, 31));
        2: w.rst = 1'b1;
        3: begin
          if ($urandom_range(0, 1) == 0) begin
            w.len = 16'($urandom_range(0, 19));
          end else begin
            // Header length beyond the segment length.
            w.doff = 4'($urandom_range(6, 15));
            w.len  = {10'd0, w.doff, 2'b00} - 16'd1;
          end
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  // Presents one word after a random idle gap, waits for it to be taken and records the
  // reply that it is owed. A word that follows without a gap keeps valid high throughout.
  task automatic send_word(seg_word_t w, bit typed, result_t typed_reply);
    int unsigned gap;
    result_t     predicted;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= w.mode;
    seq_number_i     <= w.seq;
    ack_number_i     <= w.ackn;
    fin_bit_i        <= w.fin;
    syn_bit_i        <= w.syn;
    rst_bit_i        <= w.rst;
    ack_bit_i        <= w.ack;
    data_offset_i    <= w.doff;
    segment_length_i <= w.len;
    do @(posedge clk_i); while (in_stall_o);
    predicted = track_word(w);
    pending_replies.push_back(typed ? typed_reply : predicted);
    status_tally[predicted.status]++;
    words_sent++;
  endtask

  initial begin : stimulus
    int unsigned rejected;
    // Directed script. It starts from reset with no connection, walks every rejection of
    // the SYN-sent state, completes a handshake whose acknowledgement wraps past 2^32,
    // then exercises the established state with maximum lengths, short headers and
    // restarts, and after a second handshake ends with rejections there and a last connect.
    script.push_back('{seg(MODE_SEGMENT, 0, 0, 0, 0, 0, 1, 5, 20), 1'b1,
                       reply(STATUS_IDLE_STATE, 0, 0, 0, 0, 0, 0, CONN_NONE)});
    script.push_back('{seg(MODE_SEGMENT, 0, 0, 0, 0, 0, 0, 0, 19), 1'b1,
                       reply(STATUS_SHORT, 0, 0, 0, 0, 0, 0, CONN_NONE)});
    script.push_back('{seg(MODE_SEGMENT, '1, '1, 1, 1, 1, 1, 15, 59), 1'b1,
                       reply(STATUS_SHORT, 0, 0, 0, 0, 0, 0, CONN_NONE)});
    script.push_back('{seg(MODE_SEGMENT, 0, 0, 0, 0, 1, 0, 5, 20), 1'b1,
                       reply(STATUS_RST, 0, 0, 0, 0, 0, 0, CONN_NONE)});
    script.push_back('{seg(MODE_CONNECT, '1, '1, 1, 1, 1, 1, 15, '1), 1'b1,
                       reply(STATUS_SYN_SENT, 1, 1, 0, InitLocalSeq, 0, 0, CONN_SYN_SENT)});
    script.push_back('{seg(MODE_SEGMENT, 7, 1001, 0, 1, 0, 0, 5, 20), 1'b1,
                       reply(STATUS_NOT_SYNACK, 0, 0, 0, 0, 0, 0, CONN_SYN_SENT)});
    script.push_back('{seg(MODE_SEGMENT, 7, 1001, 1, 1, 0, 1, 5, 20), 1'b1,
                       reply(STATUS_FIN_IN_SYNSENT, 0, 0, 0, 0, 0, 0, CONN_SYN_SENT)});
    script.push_back('{seg(MODE_SEGMENT, 7, 1001, 0, 1, 0, 1, 5, 21), 1'b1,
                       reply(STATUS_SYNACK_PAYLOAD, 0, 0, 0, 0, 0, 0, CONN_SYN_SENT)});
    script.push_back('{seg(MODE_SEGMENT, 7, 1000, 0, 1, 0, 1, 5, 20), 1'b1,
                       reply(STATUS_BAD_ACK, 0, 0, 0, 0, 0, 0, CONN_SYN_SENT)});
    script.push_back('{seg(MODE_SEGMENT, 7, 1001, 0, 1, 1, 1, 5, 20), 1'b1,
                       reply(STATUS_RST, 0, 0, 0, 0, 0, 0, CONN_SYN_SENT)});
    script.push_back('{seg(MODE_SEGMENT, '1, 1001, 0, 1, 0, 1, 5, 20), 1'b1,
                       reply(STATUS_HANDSHAKE_DONE, 1, 0, 1, 1001, 0, 0, CONN_ESTABLISHED)});
    script.push_back('{seg(MODE_SEGMENT, 0, 1001, 0, 1, 0, 1, 5, 20), 1'b1,
                       reply(STATUS_SYN_ESTABLISHED, 0, 0, 0, 0, 0, 0, CONN_ESTABLISHED)});
    script.push_back('{seg(MODE_SEGMENT, 5, 1001, 0, 0, 0, 1, 5, 20), 1'b1,
                       reply(STATUS_OUT_OF_ORDER, 0, 0, 0, 0, 0, 0, CONN_ESTABLISHED)});
    script.push_back('{seg(MODE_SEGMENT, 0, 0, 0, 0, 0, 0, 5, 20), 1'b1,
                       reply(STATUS_ACCEPTED_NO_ACK, 0, 0, 0, 0, 0, 0, CONN_ESTABLISHED)});
    script.push_back('{seg(MODE_SEGMENT, 0, '1, 1, 0, 0, 1, 0, '1), 1'b0, NoReply});
    script.push_back('{seg(MODE_SEGMENT, 32'h0001_0000, 0, 1, 0, 0, 0, 5, 20), 1'b0, NoReply});
    script.push_back('{seg(MODE_SEGMENT, 32'h0001_0001, 0, 0, 0, 0, 1, 4, 20), 1'b0, NoReply});
    script.push_back('{seg(MODE_SEGMENT, 32'h0001_0005, 0, 0, 0, 0, 1, 15, '1), 1'b0, NoReply});
    script.push_back('{seg(MODE_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NoReply});
    script.push_back('{seg(MODE_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NoReply});
    script.push_back('{seg(MODE_SEGMENT, 32'h7FFF_FFFF, 1, 0, 1, 0, 1, 5, 20), 1'b0, NoReply});
    script.push_back('{seg(MODE_SEGMENT, 32'h8000_0000, 0, 0, 0, 1, 1, 5, 20), 1'b1,
                       reply(STATUS_RST, 0, 0, 0, 0, 0, 0, CONN_ESTABLISHED)});
    script.push_back('{seg(MODE_SEGMENT, 32'h8000_0000, 0, 0, 0, 0, 1, 15, 59), 1'b1,
                       reply(STATUS_SHORT, 0, 0, 0, 0, 0, 0, CONN_ESTABLISHED)});
    script.push_back('{seg(MODE_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NoReply});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) begin
      send_word(script[k].word, script[k].typed, script[k].reply);
    end

    // Random part, in stretches: now and then both sides run without any idling.
    for (int unsigned n = 0; n < RandomWords; n++) begin
      if (n % 150 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_word(draw_word(), 1'b0, NoReply);
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    // Let any reply that was not asked for show up.
    repeat (8) @(posedge clk_i);

    rejected = 0;
    for (int s = STATUS_SHORT; s <= STATUS_IDLE_STATE; s++) begin
      rejected += status_tally[s];
    end
    $display("Drove %0d words (%0d scripted) and checked %0d replies.",
             words_sent, script.size(), replies_checked);
    $display("Handshakes completed %0d, segments acknowledged %0d, words rejected %0d.",
             status_tally[STATUS_HANDSHAKE_DONE], status_tally[STATUS_DATA_ACKED], rejected);
    if (fault_count == 0 && pending_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver pacing: before each reply it holds stall high for a random number of cycles,
  // then takes the reply as soon as it is offered.
  initial begin : reply_pacing
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= MaxReports) begin
        $display("%0t: reply %0d, %s expected %0h, got %0h",
                 $realtime, replies_checked, name, want, got);
      end
    end
  endfunction

  // Every reply taken is compared with the oldest one still owed.
  always @(posedge clk_i) begin : reply_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= MaxReports) begin
          $display("%0t: reply with status %0d arrived when none was owed",
                   $realtime, status_o);
        end
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 32'(status_o), 32'(want.status));
        check_field("send_segment", 32'(send_segment_o), 32'(want.send_segment));
        check_field("send_syn", 32'(send_syn_o), 32'(want.send_syn));
        check_field("send_ack", 32'(send_ack_o), 32'(want.send_ack));
        check_field("out_seq", out_seq_o, want.out_seq);
        check_field("out_ack", out_ack_o, want.out_ack);
        check_field("deliver_length", 32'(deliver_length_o), 32'(want.deliver_length));
        check_field("state_after", 32'(state_after_o), 32'(want.state_after));
        replies_checked++;
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/core/tcst_pkg.sv
rtl/core/tcst_front.sv
rtl/core/tcst_fifo.sv
rtl/core/tcst_back.sv
rtl/core/tcp_client_segment_tracker_core.sv
rtl/core/tcst_checker.sv
tb/testbench.sv
